@@ rtl/core/aarm_pkg.sv @@
// ----------------------------------------------------------------------------
// aarm_pkg
// shared widths, constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package aarm_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 14;
    localparam int AXIS_W            = 16;
    localparam int OUT_W             = 16;
    localparam int CORDIC_STEPS      = 24;
    // cordic datapath, q2.30 with headroom
    localparam int CS_W              = 34;
    localparam int PHASE_W           = 32;
    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CS_W-1:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [OUT_W-1:0] OUT_MAX    = 16'sd32767;
    localparam logic signed [OUT_W-1:0] OUT_MIN    = -16'sd32768;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
    } t_axis;

    function automatic logic signed [CS_W-1:0] atan_turn(input int idx);
        logic signed [CS_W-1:0] v;
        unique case (idx)
            0:  v = 34'sd536870912;
            1:  v = 34'sd316933406;
            2:  v = 34'sd167458907;
            3:  v = 34'sd85004756;
            4:  v = 34'sd42667331;
            5:  v = 34'sd21354465;
            6:  v = 34'sd10679838;
            7:  v = 34'sd5340245;
            8:  v = 34'sd2670163;
            9:  v = 34'sd1335087;
            10: v = 34'sd667544;
            11: v = 34'sd333772;
            12: v = 34'sd166886;
            13: v = 34'sd83443;
            14: v = 34'sd41721;
            15: v = 34'sd20860;
            16: v = 34'sd10430;
            17: v = 34'sd5215;
            18: v = 34'sd2607;
            19: v = 34'sd1303;
            20: v = 34'sd651;
            21: v = 34'sd325;
            22: v = 34'sd162;
            23: v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/aarm_if.sv @@
// ----------------------------------------------------------------------------
// aarm channel interfaces
// request (angle and axis) and response (nine matrix entries) channels
// ----------------------------------------------------------------------------
interface aarm_req_if #(
    parameter int ANGLE_BITS = aarm_pkg::ANGLE_BITS_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic signed [ANGLE_BITS-1:0]         angle;
    logic signed [aarm_pkg::AXIS_W-1:0]   axis_x;
    logic signed [aarm_pkg::AXIS_W-1:0]   axis_y;
    logic signed [aarm_pkg::AXIS_W-1:0]   axis_z;

    modport source (output valid, angle, axis_x, axis_y, axis_z, input ready);
    modport sink   (input valid, angle, axis_x, axis_y, axis_z, output ready);
endinterface

interface aarm_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [aarm_pkg::OUT_W-1:0]  m00, m01, m02;
    logic signed [aarm_pkg::OUT_W-1:0]  m10, m11, m12;
    logic signed [aarm_pkg::OUT_W-1:0]  m20, m21, m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

@@ rtl/core/axis_angle_rotation_matrix_top.sv @@
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_top
// axis-angle (rodrigues) 3x3 rotation matrix, pipelined cordic and products
// ----------------------------------------------------------------------------
//  channel   dir  payload                          flow
//  i_req     in   angle, axis_x, axis_y, axis_z     valid/ready
//  o_rsp     out  m00 .. m22                        valid/ready
//
//  one request per cycle unless the output stalls; stages in order: fold,
//  24 cordic rotations, sign fix, axis products, scaling, sum and saturate.
//  the whole pipeline advances while the output register is empty or taken;
//  a stalled output freezes every stage, nothing is lost or repeated.
//  synchronous active-low reset clears the valid bits only.
module axis_angle_rotation_matrix_top #(
    parameter int ANGLE_BITS    = aarm_pkg::ANGLE_BITS_DEF,
    parameter int FRACTION_BITS = aarm_pkg::FRACTION_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aarm_req_if.sink   i_req,
    aarm_rsp_if.source o_rsp
);
    import aarm_pkg::*;

    logic                   en;
    logic                   c_vld, c_neg;
    logic signed [CS_W-1:0] c_x, c_y;
    t_axis                  c_axis;
    t_axis                  in_axis;
    logic                   m_vld;
    logic signed [OUT_W-1:0] m [9];

    assign en      = !m_vld || o_rsp.ready;
    assign i_req.ready = en;
    assign in_axis = '{x: i_req.axis_x, y: i_req.axis_y, z: i_req.axis_z};

    aarm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_req.valid),
        .i_angle (i_req.angle),
        .i_axis  (in_axis),
        .o_vld   (c_vld),
        .o_neg   (c_neg),
        .o_x     (c_x),
        .o_y     (c_y),
        .o_axis  (c_axis)
    );

    aarm_mat #(.FRACTION_BITS(FRACTION_BITS)) u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (c_vld),
        .i_neg   (c_neg),
        .i_x     (c_x),
        .i_y     (c_y),
        .i_axis  (c_axis),
        .o_vld   (m_vld),
        .o_m     (m)
    );

    assign o_rsp.valid = m_vld;
    assign o_rsp.m00 = m[0];
    assign o_rsp.m01 = m[1];
    assign o_rsp.m02 = m[2];
    assign o_rsp.m10 = m[3];
    assign o_rsp.m11 = m[4];
    assign o_rsp.m12 = m[5];
    assign o_rsp.m20 = m[6];
    assign o_rsp.m21 = m[7];
    assign o_rsp.m22 = m[8];

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("response valid after reset");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> (o_rsp.valid && $stable(o_rsp.m00)
            && $stable(o_rsp.m11) && $stable(o_rsp.m22)))
        else $error("stalled response changed");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready == (!o_rsp.valid || o_rsp.ready))
        else $error("request ready does not follow output state");

endmodule

@@ rtl/core/aarm_cordic.sv @@
// ----------------------------------------------------------------------------
// aarm_cordic
// unrolled, one register stage per rotation, quadrant fold up front
// ----------------------------------------------------------------------------
module aarm_cordic #(
    parameter int ANGLE_BITS = aarm_pkg::ANGLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_vld,
    input  logic signed [ANGLE_BITS-1:0]          i_angle,
    input  aarm_pkg::t_axis                       i_axis,
    output logic                                  o_vld,
    output logic                                  o_neg,
    output logic signed [aarm_pkg::CS_W-1:0]      o_x,
    output logic signed [aarm_pkg::CS_W-1:0]      o_y,
    output aarm_pkg::t_axis                       o_axis
);
    import aarm_pkg::*;

    logic [PHASE_W-1:0]     phase;
    logic                   neg;
    logic [PHASE_W-1:0]     phase_f;

    logic                   r_vld  [CORDIC_STEPS+1];
    logic                   r_neg  [CORDIC_STEPS+1];
    logic signed [CS_W-1:0] r_x    [CORDIC_STEPS+1];
    logic signed [CS_W-1:0] r_y    [CORDIC_STEPS+1];
    logic signed [CS_W-1:0] r_z    [CORDIC_STEPS+1];
    t_axis                  r_axis [CORDIC_STEPS+1];

    always_comb begin
        phase   = PHASE_W'($unsigned(i_angle)) << (PHASE_W - ANGLE_BITS);
        neg     = (phase[PHASE_W-1:PHASE_W-2] == 2'b01) ||
                  (phase[PHASE_W-1:PHASE_W-2] == 2'b10);
        // half-turn move flips the top bit
        phase_f = neg ? {~phase[PHASE_W-1], phase[PHASE_W-2:0]} : phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0]  <= neg;
            r_x[0]    <= CORDIC_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= CS_W'($signed(phase_f));
            r_axis[0] <= i_axis;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [CS_W-1:0] dx;
        logic signed [CS_W-1:0] dy;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[i+1] <= r_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[i+1]  <= r_neg[i];
                r_axis[i+1] <= r_axis[i];
                if (!r_z[i][CS_W-1]) begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - atan_turn(i);
                end else begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + atan_turn(i);
                end
            end
        end
    end

    assign o_vld  = r_vld[CORDIC_STEPS];
    assign o_neg  = r_neg[CORDIC_STEPS];
    assign o_x    = r_x[CORDIC_STEPS];
    assign o_y    = r_y[CORDIC_STEPS];
    assign o_axis = r_axis[CORDIC_STEPS];

endmodule

@@ rtl/core/aarm_mat.sv @@
// ----------------------------------------------------------------------------
// aarm_mat
// sign fix, axis products, scaling by 1-c and sin, sum, round, saturate
// ----------------------------------------------------------------------------
module aarm_mat #(
    parameter int FRACTION_BITS = aarm_pkg::FRACTION_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_vld,
    input  logic                                  i_neg,
    input  logic signed [aarm_pkg::CS_W-1:0]      i_x,
    input  logic signed [aarm_pkg::CS_W-1:0]      i_y,
    input  aarm_pkg::t_axis                       i_axis,
    output logic                                  o_vld,
    output logic signed [aarm_pkg::OUT_W-1:0]     o_m [9]
);
    import aarm_pkg::*;

    localparam int PP_W   = 2 * AXIS_W;
    localparam int T_W    = CS_W + 1;
    localparam int QP_W   = PP_W + T_W;
    localparam int LP_W   = AXIS_W + CS_W;
    localparam int TERM_W = 36;
    localparam int SUM_W  = TERM_W + 2;
    localparam int QSH    = 2 * FRACTION_BITS;
    localparam int FSH    = 30 - FRACTION_BITS;

    // product index: xx yy zz xy zx zy
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_ZX = 4;
    localparam int P_ZY = 5;
    // linear index: x*s y*s z*s
    localparam int L_X = 0;
    localparam int L_Y = 1;
    localparam int L_Z = 2;

    // stage a: signs applied, t formed
    logic                     r_vld_a, r_vld_b, r_vld_c, r_vld_d;
    logic signed [CS_W-1:0]   r_c_a, r_s_a;
    logic signed [T_W-1:0]    r_t_a;
    t_axis                    r_axis_a;
    // stage b: axis products
    logic signed [CS_W-1:0]   r_c_b;
    logic signed [T_W-1:0]    r_t_b;
    logic signed [PP_W-1:0]   r_pp_b [6];
    logic signed [LP_W-1:0]   r_lp_b [3];
    // stage c: rounded terms
    logic signed [CS_W-1:0]   r_c_c;
    logic signed [TERM_W-1:0] r_q_c [6];
    logic signed [TERM_W-1:0] r_l_c [3];
    // stage d: outputs
    logic signed [OUT_W-1:0]  r_m_d [9];

    logic signed [QP_W-1:0]   qp   [6];
    logic signed [QP_W-1:0]   qr   [6];
    logic signed [LP_W-1:0]   lr   [3];
    logic signed [SUM_W-1:0]  sum  [9];
    logic signed [SUM_W-1:0]  rnd  [9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
            r_vld_d <= r_vld_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_a    <= i_neg ? -i_x : i_x;
            r_s_a    <= i_neg ? -i_y : i_y;
            r_t_a    <= T_W'(ONE_Q30) - (i_neg ? -T_W'(i_x) : T_W'(i_x));
            r_axis_a <= i_axis;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_b         <= r_c_a;
            r_t_b         <= r_t_a;
            r_pp_b[P_XX]  <= PP_W'(r_axis_a.x) * PP_W'(r_axis_a.x);
            r_pp_b[P_YY]  <= PP_W'(r_axis_a.y) * PP_W'(r_axis_a.y);
            r_pp_b[P_ZZ]  <= PP_W'(r_axis_a.z) * PP_W'(r_axis_a.z);
            r_pp_b[P_XY]  <= PP_W'(r_axis_a.x) * PP_W'(r_axis_a.y);
            r_pp_b[P_ZX]  <= PP_W'(r_axis_a.z) * PP_W'(r_axis_a.x);
            r_pp_b[P_ZY]  <= PP_W'(r_axis_a.z) * PP_W'(r_axis_a.y);
            r_lp_b[L_X]   <= LP_W'(r_axis_a.x) * LP_W'(r_s_a);
            r_lp_b[L_Y]   <= LP_W'(r_axis_a.y) * LP_W'(r_s_a);
            r_lp_b[L_Z]   <= LP_W'(r_axis_a.z) * LP_W'(r_s_a);
        end
    end

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            qp[k] = QP_W'(r_pp_b[k]) * QP_W'(r_t_b);
            qr[k] = (qp[k] + (QP_W'(1) <<< (QSH - 1))) >>> QSH;
        end
        for (int k = 0; k < 3; k++) begin
            lr[k] = (r_lp_b[k] + (LP_W'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_c <= r_c_b;
            for (int k = 0; k < 6; k++) r_q_c[k] <= TERM_W'(qr[k]);
            for (int k = 0; k < 3; k++) r_l_c[k] <= TERM_W'(lr[k]);
        end
    end

    always_comb begin
        sum[0] = SUM_W'(r_c_c)        + SUM_W'(r_q_c[P_XX]);
        sum[1] = SUM_W'(r_q_c[P_XY])  + SUM_W'(r_l_c[L_Z]);
        sum[2] = SUM_W'(r_q_c[P_ZX])  - SUM_W'(r_l_c[L_Y]);
        sum[3] = SUM_W'(r_q_c[P_XY])  - SUM_W'(r_l_c[L_Z]);
        sum[4] = SUM_W'(r_c_c)        + SUM_W'(r_q_c[P_YY]);
        sum[5] = SUM_W'(r_q_c[P_ZY])  + SUM_W'(r_l_c[L_X]);
        sum[6] = SUM_W'(r_q_c[P_ZX])  + SUM_W'(r_l_c[L_Y]);
        sum[7] = SUM_W'(r_q_c[P_ZY])  - SUM_W'(r_l_c[L_X]);
        sum[8] = SUM_W'(r_c_c)        + SUM_W'(r_q_c[P_ZZ]);
        for (int k = 0; k < 9; k++) begin
            rnd[k] = (sum[k] + (SUM_W'(1) <<< (FSH - 1))) >>> FSH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                if (rnd[k] > SUM_W'(OUT_MAX)) begin
                    r_m_d[k] <= OUT_MAX;
                end else if (rnd[k] < SUM_W'(OUT_MIN)) begin
                    r_m_d[k] <= OUT_MIN;
                end else begin
                    r_m_d[k] <= OUT_W'(rnd[k]);
                end
            end
        end
    end

    assign o_vld = r_vld_d;
    assign o_m   = r_m_d;

endmodule
